// File: rtl/core/xsrf_pkg.sv
package xsrf_pkg;

	// stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int unsigned IN_BITS  = 50;
	localparam int unsigned IN_W     = 56;
	localparam int unsigned OUT_BITS = 37;
	localparam int unsigned OUT_W    = 40;

	// operation codes, code seven is a no-op
	typedef enum logic [2:0] {
		OP_SHL = 3'd0,
		OP_SHR = 3'd1,
		OP_SAR = 3'd2,
		OP_ROL = 3'd3,
		OP_ROR = 3'd4,
		OP_RCL = 3'd5,
		OP_RCR = 3'd6
	} op_t;

	// operand size codes, code three behaves as 32 bits
	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;

	// input transaction, first field in the lowest bits
	typedef struct packed {
		logic [IN_W-IN_BITS-1:0] pad;
		logic                    parity_in;
		logic                    zero_in;
		logic                    sign_in;
		logic                    overflow_in;
		logic                    carry_in;
		logic [7:0]              shift_count;
		logic [31:0]             operand_value;
		logic [1:0]              operand_size;
		op_t                     opcode;
	} xsrf_in_t;

	// result transaction, first field in the lowest bits
	typedef struct packed {
		logic [OUT_W-OUT_BITS-1:0] pad;
		logic                      parity_out;
		logic                      zero_out;
		logic                      sign_out;
		logic                      overflow_out;
		logic                      carry_out;
		logic [31:0]               result_value;
	} xsrf_out_t;

	// operand width in bits
	function automatic logic [5:0] size_bits(input logic [1:0] size);
		logic [5:0] w;
		case (size)
			SIZE_8:  w = 6'd8;
			SIZE_16: w = 6'd16;
			default: w = 6'd32;
		endcase
		return w;
	endfunction

	// mask of the operand bits
	function automatic logic [31:0] size_mask(input logic [1:0] size);
		logic [31:0] m;
		case (size)
			SIZE_8:  m = 32'h0000_00FF;
			SIZE_16: m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// top bit of the operand
	function automatic logic msb_of(input logic [31:0] val, input logic [1:0] size);
		logic b;
		case (size)
			SIZE_8:  b = val[7];
			SIZE_16: b = val[15];
			default: b = val[31];
		endcase
		return b;
	endfunction

	// bit below the top bit of the operand
	function automatic logic msb2_of(input logic [31:0] val, input logic [1:0] size);
		logic b;
		case (size)
			SIZE_8:  b = val[6];
			SIZE_16: b = val[14];
			default: b = val[30];
		endcase
		return b;
	endfunction

	// count modulo size plus one for rotates through carry
	function automatic logic [4:0] rc_mod(input logic [4:0] c, input logic [1:0] size);
		logic [4:0] t;
		case (size)
			SIZE_8: begin
				if (c >= 5'd27)
					t = c - 5'd27;
				else if (c >= 5'd18)
					t = c - 5'd18;
				else if (c >= 5'd9)
					t = c - 5'd9;
				else
					t = c;
			end
			SIZE_16: t = (c >= 5'd17) ? c - 5'd17 : c;
			default: t = c;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/core/xsrf_datapath.sv
module xsrf_datapath
	import xsrf_pkg::*;
(
	input  xsrf_in_t  item,
	output xsrf_out_t res
);

	logic [1:0]  sz;
	logic [31:0] mask;
	logic [31:0] v;
	logic [4:0]  c;
	logic        cnt_one;
	logic [5:0]  sbits;

	// shift paths
	logic [63:0] shl_wide;
	logic [31:0] shl_r;
	logic        shl_cf;
	logic [31:0] shr_r;
	logic        shr_cf;
	logic [31:0] sar_sx;
	logic [31:0] sar_r;
	logic        sar_cf;

	// shared rotator, field of w bits
	logic        rc;
	logic        left;
	logic [5:0]  w;
	logic [4:0]  t;
	logic [5:0]  amt_l;
	logic [5:0]  amt_r;
	logic [32:0] rot_x;
	logic [32:0] wmask;
	logic [32:0] rot_y;
	logic [31:0] rot_r;
	logic        rot_cf;

	logic [31:0] r;
	logic        cf;
	logic        of;
	logic        sf;
	logic        zf;
	logic        pf;

	// operand, size and masked count
	always_comb begin
		sz      = item.operand_size;
		mask    = size_mask(sz);
		v       = item.operand_value & mask;
		c       = item.shift_count[4:0];
		cnt_one = (c == 5'd1);
		sbits   = size_bits(sz);
	end

	// logical and arithmetic shifts
	always_comb begin
		shl_wide = {32'd0, v} << c;
		shl_r    = shl_wide[31:0] & mask;
		case (sz)
			SIZE_8:  shl_cf = shl_wide[8];
			SIZE_16: shl_cf = shl_wide[16];
			default: shl_cf = shl_wide[32];
		endcase
		shr_r  = v >> c;
		shr_cf = v[c - 5'd1];
		sar_sx = msb_of(v, sz) ? (v | ~mask) : v;
		sar_r  = 32'($signed(sar_sx) >>> c) & mask;
		sar_cf = sar_sx[c - 5'd1];
	end

	// rotator over size bits, or size plus one with the carry on top
	always_comb begin
		rc   = (item.opcode == OP_RCL) || (item.opcode == OP_RCR);
		left = (item.opcode == OP_ROL) || (item.opcode == OP_RCL);
		w    = rc ? sbits + 6'd1 : sbits;
		if (rc)
			t = rc_mod(c, sz);
		else begin
			case (sz)
				SIZE_8:  t = {2'd0, c[2:0]};
				SIZE_16: t = {1'b0, c[3:0]};
				default: t = c;
			endcase
		end
		amt_l = left ? {1'b0, t} : w - {1'b0, t};
		amt_r = left ? w - {1'b0, t} : {1'b0, t};
		rot_x = {1'b0, v};
		if (rc)
			rot_x = rot_x | (33'(item.carry_in) << sbits);
		wmask = (33'd1 << w) - 33'd1;
		rot_y = ((rot_x << amt_l) | (rot_x >> amt_r)) & wmask;
		rot_r = rot_y[31:0] & mask;
		case (sz)
			SIZE_8:  rot_cf = rot_y[8];
			SIZE_16: rot_cf = rot_y[16];
			default: rot_cf = rot_y[32];
		endcase
	end

	// result and flag selection
	always_comb begin
		r  = v;
		cf = item.carry_in;
		of = item.overflow_in;
		sf = item.sign_in;
		zf = item.zero_in;
		pf = item.parity_in;
		if (c != 5'd0) begin
			case (item.opcode)
				OP_SHL: begin
					r  = shl_r;
					cf = shl_cf;
					if (cnt_one)
						of = msb_of(shl_r, sz) ^ shl_cf;
				end
				OP_SHR: begin
					r  = shr_r;
					cf = shr_cf;
					if (cnt_one)
						of = msb_of(v, sz);
				end
				OP_SAR: begin
					r  = sar_r;
					cf = sar_cf;
					if (cnt_one)
						of = 1'b0;
				end
				OP_ROL: begin
					r  = rot_r;
					cf = rot_r[0];
					if (cnt_one)
						of = msb_of(rot_r, sz) ^ rot_r[0];
				end
				OP_ROR: begin
					r  = rot_r;
					cf = msb_of(rot_r, sz);
					if (cnt_one)
						of = msb_of(rot_r, sz) ^ msb2_of(rot_r, sz);
				end
				OP_RCL: begin
					r  = rot_r;
					cf = rot_cf;
					if (cnt_one)
						of = msb_of(rot_r, sz) ^ rot_cf;
				end
				OP_RCR: begin
					r  = rot_r;
					cf = rot_cf;
					if (cnt_one)
						of = item.carry_in ^ msb_of(v, sz);
				end
				default: begin
					r = v;
				end
			endcase
			// shifts recompute sign, zero and parity
			if ((item.opcode == OP_SHL) || (item.opcode == OP_SHR) ||
			    (item.opcode == OP_SAR)) begin
				sf = msb_of(r, sz);
				zf = (r == 32'd0);
				pf = ~^r[7:0];
			end
		end
	end

	// pack result
	always_comb begin
		res              = '0;
		res.result_value = r;
		res.carry_out    = cf;
		res.overflow_out = of;
		res.sign_out     = sf;
		res.zero_out     = zf;
		res.parity_out   = pf;
	end

endmodule

// File: rtl/core/x86_shift_rotate_flags_unit.sv
// x86 shift and rotate unit: executes SHL/SAL, SHR, SAR, ROL, ROR, RCL and RCR on an 8, 16 or
// 32 bit operand and returns the result with updated CF, OF, SF, ZF and PF. It takes one
// transaction per clock cycle unless m_axis_tready stalls the output. Each item goes from the
// input register to the result register through separate SHL, SHR and SAR shifters and one
// shared rotator, whose single pass sets the rate. The result register lets a new input be
// taken while a finished result still waits on m_axis_tready. The count is masked to five bits;
// a zero masked count, or opcode seven, returns the masked operand with all flags unchanged.
module x86_shift_rotate_flags_unit
	import xsrf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] opcode, [4:3] operand_size, [36:5] operand_value, [44:37] shift_count,
	// [45] carry_in, [46] overflow_in, [47] sign_in, [48] zero_in, [49] parity_in, rest zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [31:0] result_value, [32] carry_out, [33] overflow_out, [34] sign_out,
	// [35] zero_out, [36] parity_out, rest zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	xsrf_in_t  item_s1;
	logic      valid_s1;
	xsrf_out_t res_comb;
	xsrf_out_t res_s2;
	logic      valid_s2;
	logic      adv_s2;
	logic      adv_s1;

	// pipeline flow control
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid)
			item_s1 <= xsrf_in_t'(s_axis_tdata);
	end

	xsrf_datapath u_datapath (
		.item (item_s1),
		.res  (res_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1)
			res_s2 <= res_comb;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

endmodule

// File: rtl/core/xsrf_checker.sv
module xsrf_checker
	import xsrf_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a result stalled on the output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// an empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while output empty");

	// a new result follows an accepted input through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result appeared without a matching input");

	// padding of a result is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:OUT_BITS] == '0))
		else $error("result padding not zero");

endmodule

bind x86_shift_rotate_flags_unit xsrf_checker u_xsrf_checker (.*);

// File: verif/x86_shift_rotate_flags_unit_tb.sv
`timescale 1ns / 1ps

module x86_shift_rotate_flags_unit_tb;
	import xsrf_pkg::*;

	// codes the package leaves unnamed
	localparam logic [2:0] OP_NOP       = 3'd7;
	localparam logic [1:0] SIZE_32      = 2'd2;
	localparam logic [1:0] SIZE_32_ALT  = 2'd3;

	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;

	// one row of the directed table
	typedef struct {
		xsrf_in_t  item;
		bit        typed;
		xsrf_out_t want;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	// [2:0] opcode, [4:3] operand_size, [36:5] operand_value, [44:37] shift_count,
	// [45] carry_in, [46] overflow_in, [47] sign_in, [48] zero_in, [49] parity_in, rest zero
	logic [IN_W-1:0] s_axis_tdata;
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	// [31:0] result_value, [32] carry_out, [33] overflow_out, [34] sign_out,
	// [35] zero_out, [36] parity_out, rest zero
	logic [OUT_W-1:0] m_axis_tdata;

	xsrf_out_t   pending_results[$];
	stim_row_t   directed_rows[$];
	xsrf_out_t   got_res;
	xsrf_out_t   want_res;
	int unsigned mismatches;
	int unsigned results_checked;
	int unsigned items_sent;
	int unsigned input_stall_cycles;
	int unsigned cycle_count;
	int unsigned op_hits[8];
	bit          hold_off_request;

	x86_shift_rotate_flags_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// build one input transaction, flags are {parity, zero, sign, overflow, carry}
	function automatic xsrf_in_t mk_item(input logic [2:0] op, input logic [1:0] size,
			input logic [31:0] val, input logic [7:0] cnt, input logic [4:0] flags);
		xsrf_in_t t;
		t = '0;
		t.opcode        = op_t'(op);
		t.operand_size  = size;
		t.operand_value = val;
		t.shift_count   = cnt;
		t.carry_in      = flags[0];
		t.overflow_in   = flags[1];
		t.sign_in       = flags[2];
		t.zero_in       = flags[3];
		t.parity_in     = flags[4];
		return t;
	endfunction

	// build one result, flags in the same order as above
	function automatic xsrf_out_t mk_res(input logic [31:0] val, input logic [4:0] flags);
		xsrf_out_t o;
		o = '0;
		o.result_value = val;
		o.carry_out    = flags[0];
		o.overflow_out = flags[1];
		o.sign_out     = flags[2];
		o.zero_out     = flags[3];
		o.parity_out   = flags[4];
		return o;
	endfunction

	// rotate left by r inside a field of w bits
	function automatic logic [63:0] rotl_field(input logic [63:0] x, input int unsigned r,
			input int unsigned w);
		logic [63:0] m;
		m = (64'd1 << w) - 64'd1;
		x = x & m;
		return ((x << r) | (x >> (w - r))) & m;
	endfunction

	// expected result of one shift or rotate
	function automatic xsrf_out_t predict_shift_rotate(input xsrf_in_t t);
		int unsigned w;
		int unsigned cnt;
		int unsigned red;
		logic [63:0] msk;
		logic [63:0] val;
		logic [63:0] res;
		logic [63:0] wide;
		logic [63:0] y;
		logic        cf, of, sf, zf, pf;
		bit          is_shift;
		xsrf_out_t   o;
		w = (t.operand_size == SIZE_8) ? 8 : (t.operand_size == SIZE_16) ? 16 : 32;
		msk = (64'd1 << w) - 64'd1;
		val = {32'd0, t.operand_value} & msk;
		cnt = int'(t.shift_count[4:0]);
		cf = t.carry_in;
		of = t.overflow_in;
		sf = t.sign_in;
		zf = t.zero_in;
		pf = t.parity_in;
		res = val;
		is_shift = 1'b0;
		if (cnt != 0) begin
			case (t.opcode)
				OP_SHL: begin
					is_shift = 1'b1;
					wide = val << cnt;
					res = wide & msk;
					cf = wide[w];
					if (cnt == 1)
						of = res[w-1] ^ cf;
				end
				OP_SHR: begin
					is_shift = 1'b1;
					res = val >> cnt;
					cf = val[cnt-1];
					if (cnt == 1)
						of = val[w-1];
				end
				OP_SAR: begin
					// sign extend to 64 bits, then shift
					is_shift = 1'b1;
					wide = val[w-1] ? (val | ~msk) : val;
					res = (wide >> cnt) & msk;
					cf = wide[cnt-1];
					if (cnt == 1)
						of = 1'b0;
				end
				OP_ROL: begin
					red = cnt % w;
					if (red != 0)
						res = rotl_field(val, red, w);
					cf = res[0];
					if (cnt == 1)
						of = res[w-1] ^ cf;
				end
				OP_ROR: begin
					red = cnt % w;
					if (red != 0)
						res = rotl_field(val, w - red, w);
					cf = res[w-1];
					if (cnt == 1)
						of = res[w-1] ^ res[w-2];
				end
				OP_RCL, OP_RCR: begin
					// carry sits above the operand, field is w+1 bits wide
					red = cnt % (w + 1);
					if (t.opcode == OP_RCR && cnt == 1)
						of = cf ^ val[w-1];
					if (red != 0) begin
						y = rotl_field((64'(cf) << w) | val,
							(t.opcode == OP_RCL) ? red : w + 1 - red, w + 1);
						res = y & msk;
						cf = y[w];
					end
					if (t.opcode == OP_RCL && cnt == 1)
						of = res[w-1] ^ cf;
				end
				default: begin
				end
			endcase
		end
		// shifts recompute sign, zero and parity
		if (is_shift) begin
			sf = res[w-1];
			zf = (res == 64'd0);
			pf = ~^res[7:0];
		end
		o = '0;
		o.result_value = res[31:0];
		o.carry_out    = cf;
		o.overflow_out = of;
		o.sign_out     = sf;
		o.zero_out     = zf;
		o.parity_out   = pf;
		return o;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
		mismatches++;
	endtask

	// idle cycles for one transaction, none in a calm stretch
	function automatic int unsigned draw_idle(input bit calm);
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	// offer one transaction, record its expected result once accepted
	task automatic send_item(input xsrf_in_t item, input bit typed, input xsrf_out_t want,
			input bit calm);
		int unsigned gap;
		gap = draw_idle(calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= item;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(typed ? want : predict_shift_rotate(item));
		op_hits[item.opcode]++;
		items_sent++;
	endtask

	// result checker and input stall count
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !s_axis_tready)
				input_stall_cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				got_res = xsrf_out_t'(m_axis_tdata);
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: expected none, actual 0x%0h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					want_res = pending_results.pop_front();
					results_checked++;
					if (got_res.result_value !== want_res.result_value)
						report_mismatch("result_value", want_res.result_value,
							got_res.result_value);
					if (got_res.carry_out !== want_res.carry_out)
						report_mismatch("carry_out", 32'(want_res.carry_out),
							32'(got_res.carry_out));
					if (got_res.overflow_out !== want_res.overflow_out)
						report_mismatch("overflow_out", 32'(want_res.overflow_out),
							32'(got_res.overflow_out));
					if (got_res.sign_out !== want_res.sign_out)
						report_mismatch("sign_out", 32'(want_res.sign_out),
							32'(got_res.sign_out));
					if (got_res.zero_out !== want_res.zero_out)
						report_mismatch("zero_out", 32'(want_res.zero_out),
							32'(got_res.zero_out));
					if (got_res.parity_out !== want_res.parity_out)
						report_mismatch("parity_out", 32'(want_res.parity_out),
							32'(got_res.parity_out));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls, calm stretches and one long hold-off
	initial begin
		int unsigned stall;
		int unsigned taken;
		bit          calm;
		taken = 0;
		calm = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			stall = draw_idle(calm);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	// reset, directed table, random stream, drain and verdict
	initial begin
		logic [2:0]  rnd_op;
		logic [1:0]  rnd_size;
		logic [31:0] rnd_val;
		logic [7:0]  rnd_cnt;
		logic [7:0]  edge_counts[8];
		bit          calm;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		input_stall_cycles = 0;
		cycle_count = 0;
		hold_off_request = 1'b0;
		calm = 1'b0;
		foreach (op_hits[k])
			op_hits[k] = 0;
		edge_counts = '{8'd0, 8'd7, 8'd8, 8'd9, 8'd15, 8'd16, 8'd17, 8'd31};
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;

		// masked count of zero passes everything through
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROL, SIZE_32, 32'hDEAD_BEEF, 8'h20,
			5'b10101), 1'b1, mk_res(32'hDEAD_BEEF, 5'b10101)});
		// no-op code
		directed_rows.push_back(stim_row_t'{mk_item(OP_NOP, SIZE_8, 32'h1234_5678, 8'h03,
			5'b11111), 1'b1, mk_res(32'h0000_0078, 5'b11111)});
		// size code three acts as 32 bits
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHR, SIZE_32_ALT, 32'h8000_0000, 8'h1F,
			5'b00000), 1'b1, mk_res(32'h0000_0001, 5'b00000)});
		// shift left by one with carry out
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHL, SIZE_8, 32'h0000_00FF, 8'h01,
			5'b00000), 1'b1, mk_res(32'h0000_00FE, 5'b00101)});
		// shift left past the width
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHL, SIZE_8, 32'h0000_0001, 8'h09,
			5'b00111), 1'b1, mk_res(32'h0000_0000, 5'b11010)});
		// arithmetic shift by the full masked count
		directed_rows.push_back(stim_row_t'{mk_item(OP_SAR, SIZE_16, 32'h0000_8000, 8'h1F,
			5'b00000), 1'b1, mk_res(32'h0000_FFFF, 5'b10101)});
		// the rest goes through the predictor
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHR, SIZE_32, 32'hFFFF_FFFF, 8'h01,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHR, SIZE_8, 32'hFFFF_FF80, 8'h08,
			5'b11111), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHR, SIZE_16, 32'h0001_FFFF, 8'h11,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_SAR, SIZE_8, 32'h0000_0081, 8'h01,
			5'b00010), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_SHL, SIZE_32, 32'hFFFF_FFFF, 8'hFF,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROL, SIZE_8, 32'hABCD_EF81, 8'h08,
			5'b00010), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROL, SIZE_32, 32'h8000_0001, 8'h01,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROL, SIZE_8, 32'h0000_0000, 8'h1F,
			5'b11111), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROR, SIZE_16, 32'h0000_8001, 8'h10,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_ROR, SIZE_32, 32'h4000_0001, 8'h01,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCL, SIZE_8, 32'h0000_00A5, 8'h09,
			5'b00011), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCR, SIZE_8, 32'h0000_0000, 8'h09,
			5'b00001), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCL, SIZE_16, 32'h0000_8000, 8'h11,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCR, SIZE_16, 32'h0000_8000, 8'h01,
			5'b00001), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCL, SIZE_32, 32'hFFFF_FFFF, 8'h1F,
			5'b00000), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCR, SIZE_32, 32'h0000_0001, 8'h01,
			5'b00001), 1'b0, '0});
		directed_rows.push_back(stim_row_t'{mk_item(OP_RCL, SIZE_8, 32'h0000_0080, 8'h01,
			5'b00000), 1'b0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want,
				1'b0);

		// random stream
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// long receiver hold-off while items keep coming
			if (i == RANDOM_ITEMS / 3) begin
				hold_off_request = 1'b1;
				calm = 1'b1;
			end
			rnd_op = ($urandom_range(0, 15) == 0) ? OP_NOP : 3'($urandom_range(0, 6));
			rnd_size = ($urandom_range(0, 9) == 0) ? SIZE_32_ALT : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 7))
				0: rnd_val = 32'h0000_0000;
				1: rnd_val = 32'hFFFF_FFFF;
				2: rnd_val = 32'd1 << $urandom_range(0, 31);
				3: rnd_val = ~(32'd1 << $urandom_range(0, 31));
				default: rnd_val = $urandom;
			endcase
			rnd_cnt[7:5] = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: rnd_cnt[4:0] = 5'd1;
				1: rnd_cnt[4:0] = edge_counts[$urandom_range(0, 7)][4:0];
				default: rnd_cnt[4:0] = 5'($urandom_range(0, 31));
			endcase
			send_item(mk_item(rnd_op, rnd_size, rnd_val, rnd_cnt, 5'($urandom_range(0, 31))),
				1'b0, '0, calm);
		end
		s_axis_tvalid <= 1'b0;

		// drain
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d transactions, checked %0d results, %0d cycles of input backpressure",
			items_sent, results_checked, input_stall_cycles);
		$display("per opcode shl %0d shr %0d sar %0d rol %0d ror %0d rcl %0d rcr %0d nop %0d",
			op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
			op_hits[6], op_hits[7]);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: x86_shift_rotate_flags_unit.f
rtl/core/xsrf_pkg.sv
rtl/core/xsrf_datapath.sv
rtl/core/x86_shift_rotate_flags_unit.sv
rtl/core/xsrf_checker.sv
verif/x86_shift_rotate_flags_unit_tb.sv
